// ----- src/srp_pkg.sv -----
`timescale 1ns / 1ps
package srp_pkg;

  // fixed field widths
  localparam int AXIS_W    = 13;
  localparam int RECT_W    = 12;
  localparam int CNT_W     = 9;
  localparam int CFG_IDX_W = 2;

  // largest atlas side, tied to the field widths above
  localparam int MAX_SIDE  = 4096;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = 2'd1;

  // operation codes
  localparam logic OP_PACK  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // microcode step counter
  localparam int UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  // datapath operations, one per control word
  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_ADVANCE,
    DP_PLACE,
    DP_EMIT_OK,
    DP_EMIT_FAIL
  } dp_op_t;

  // jump conditions
  typedef enum logic [2:0] {
    JC_ACCEPT,
    JC_QDONE,
    JC_NO_FIT,
    JC_QUERY,
    JC_OUT_FREE
  } jcond_t;

  typedef struct packed {
    dp_op_t op;
    jcond_t cond;
    upc_t   taken;
    upc_t   fall;
  } ucode_t;

  // flags from the datapath that the sequencer branches on
  typedef struct packed {
    logic accept;
    logic qdone;
    logic no_fit;
    logic is_query;
    logic out_free;
  } dp_status_t;

  // step addresses
  localparam upc_t UA_IDLE      = 3'd0;
  localparam upc_t UA_ADVANCE   = 3'd1;
  localparam upc_t UA_FIT       = 3'd2;
  localparam upc_t UA_PLACE     = 3'd3;
  localparam upc_t UA_EMIT_OK   = 3'd4;
  localparam upc_t UA_EMIT_FAIL = 3'd5;

  // control store
  function automatic ucode_t ucode_rom(upc_t addr);
    ucode_t w;
    case (addr)
      UA_IDLE:      w = '{op: DP_LOAD,      cond: JC_ACCEPT,   taken: UA_ADVANCE,
                          fall: UA_IDLE};
      UA_ADVANCE:   w = '{op: DP_ADVANCE,   cond: JC_QDONE,    taken: UA_EMIT_OK,
                          fall: UA_FIT};
      UA_FIT:       w = '{op: DP_NOP,       cond: JC_NO_FIT,   taken: UA_EMIT_FAIL,
                          fall: UA_PLACE};
      UA_PLACE:     w = '{op: DP_PLACE,     cond: JC_QUERY,    taken: UA_ADVANCE,
                          fall: UA_EMIT_OK};
      UA_EMIT_OK:   w = '{op: DP_EMIT_OK,   cond: JC_OUT_FREE, taken: UA_IDLE,
                          fall: UA_EMIT_OK};
      UA_EMIT_FAIL: w = '{op: DP_EMIT_FAIL, cond: JC_OUT_FREE, taken: UA_IDLE,
                          fall: UA_EMIT_FAIL};
      default:      w = '{op: DP_LOAD,      cond: JC_ACCEPT,   taken: UA_ADVANCE,
                          fall: UA_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- src/shelf_rect_packer.sv -----
`timescale 1ns / 1ps
// pack: the transaction is taken in the load step, then advance, fit, place and emit
// query: advance, fit and place per rectangle, one step of the shared place unit each
// a failing item ends as soon as a rectangle overruns the bottom edge
// a new item is taken only in the load step; an emit step waits out a result stall
// synchronous reset clears cursor, row height and full flag, atlas sizes to 1024
module shelf_rect_packer #(
  parameter int MAX_QUERY_COUNT = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [srp_pkg::RECT_W-1:0]    in_rect_width,
  input  logic [srp_pkg::RECT_W-1:0]    in_rect_height,
  input  logic [srp_pkg::CNT_W-1:0]     in_rect_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_success,
  output logic [srp_pkg::AXIS_W-1:0]    out_left,
  output logic [srp_pkg::AXIS_W-1:0]    out_top,
  output logic [srp_pkg::AXIS_W-1:0]    out_right,
  output logic [srp_pkg::AXIS_W-1:0]    out_bottom,
  output logic                          out_atlas_full,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srp_pkg::AXIS_W-1:0]    cfg_data
);
  import srp_pkg::*;

  localparam int SIDE_RST = (1024 > MAX_SIDE) ? MAX_SIDE : 1024;

  logic [AXIS_W-1:0] atlas_w_r, atlas_w_nxt;
  logic [AXIS_W-1:0] atlas_h_r, atlas_h_nxt;
  logic [AXIS_W-1:0] cfg_clamped;
  logic              cfg_write;
  dp_op_t            op;
  dp_status_t        status;

  // configuration writes, saturated to the largest side on the way in
  assign cfg_ready   = 1'b1;
  assign cfg_write   = cfg_valid && cfg_ready;
  assign cfg_clamped = (32'(cfg_data) > MAX_SIDE) ? AXIS_W'(MAX_SIDE) : cfg_data;

  always_comb begin
    atlas_w_nxt = atlas_w_r;
    atlas_h_nxt = atlas_h_r;
    if (cfg_write) begin
      case (cfg_index)
        REG_ATLAS_WIDTH:  atlas_w_nxt = cfg_clamped;
        REG_ATLAS_HEIGHT: atlas_h_nxt = cfg_clamped;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_w_r <= AXIS_W'(SIDE_RST);
      atlas_h_r <= AXIS_W'(SIDE_RST);
    end else begin
      atlas_w_r <= atlas_w_nxt;
      atlas_h_r <= atlas_h_nxt;
    end
  end

  // microcode sequencer
  srp_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .op     (op)
  );

  // placement datapath and result register
  srp_dp #(
    .MAX_QUERY_COUNT (MAX_QUERY_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .status         (status),
    .atlas_w        (atlas_w_r),
    .atlas_h        (atlas_h_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_rect_count  (in_rect_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_success    (out_success),
    .out_left       (out_left),
    .out_top        (out_top),
    .out_right      (out_right),
    .out_bottom     (out_bottom),
    .out_atlas_full (out_atlas_full)
  );

endmodule

// ----- src/srp_seq.sv -----
`timescale 1ns / 1ps
module srp_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  srp_pkg::dp_status_t status,
  output srp_pkg::dp_op_t     op
);
  import srp_pkg::*;

  upc_t   upc_r;
  upc_t   upc_nxt;
  ucode_t word;
  logic   cond_true;

  // control word fetch
  assign word = ucode_rom(upc_r);
  assign op   = word.op;

  // jump condition select
  always_comb begin
    case (word.cond)
      JC_ACCEPT:   cond_true = status.accept;
      JC_QDONE:    cond_true = status.qdone;
      JC_NO_FIT:   cond_true = status.no_fit;
      JC_QUERY:    cond_true = status.is_query;
      JC_OUT_FREE: cond_true = status.out_free;
      default:     cond_true = 1'b0;
    endcase
    upc_nxt = cond_true ? word.taken : word.fall;
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ----- src/srp_dp.sv -----
`timescale 1ns / 1ps
module srp_dp #(
  parameter int MAX_QUERY_COUNT = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  srp_pkg::dp_op_t             op,
  output srp_pkg::dp_status_t         status,
  input  logic [srp_pkg::AXIS_W-1:0]  atlas_w,
  input  logic [srp_pkg::AXIS_W-1:0]  atlas_h,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [srp_pkg::RECT_W-1:0]  in_rect_width,
  input  logic [srp_pkg::RECT_W-1:0]  in_rect_height,
  input  logic [srp_pkg::CNT_W-1:0]   in_rect_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_success,
  output logic [srp_pkg::AXIS_W-1:0]  out_left,
  output logic [srp_pkg::AXIS_W-1:0]  out_top,
  output logic [srp_pkg::AXIS_W-1:0]  out_right,
  output logic [srp_pkg::AXIS_W-1:0]  out_bottom,
  output logic                        out_atlas_full
);
  import srp_pkg::*;

  localparam int CURSOR_MAX = 2 * MAX_SIDE - 1;
  localparam int CW = $clog2(2 * MAX_SIDE);
  localparam int DW = ((CW > AXIS_W) ? CW : AXIS_W) + 1;
  localparam int QW = $clog2(MAX_QUERY_COUNT + 1);

  // committed state
  logic [AXIS_W-1:0] cursor_x_r, cursor_x_nxt;
  logic [CW-1:0]     cursor_y_r, cursor_y_nxt;
  logic [RECT_W-1:0] row_h_r, row_h_nxt;
  logic              full_r, full_nxt;

  // working copy for the current transaction
  logic              query_r, query_nxt;
  logic [RECT_W-1:0] w_r, w_nxt;
  logic [RECT_W-1:0] h_r, h_nxt;
  logic [QW-1:0]     cnt_r, cnt_nxt;
  logic [AXIS_W-1:0] x_r, x_nxt;
  logic [CW-1:0]     y_r, y_nxt;
  logic [RECT_W-1:0] s_r, s_nxt;
  logic [AXIS_W-1:0] cl_r, cl_nxt, ct_r, ct_nxt, cr_r, cr_nxt, cb_r, cb_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic              out_success_r, out_success_nxt;
  logic [AXIS_W-1:0] out_left_r, out_left_nxt, out_top_r, out_top_nxt;
  logic [AXIS_W-1:0] out_right_r, out_right_nxt, out_bottom_r, out_bottom_nxt;
  logic              out_full_r, out_full_nxt;

  logic          accept;
  logic          out_free;
  logic [DW-1:0] x_sum;
  logic [DW-1:0] y_step_sum;
  logic [DW-1:0] y_h_sum;
  logic [CW-1:0] y_wrapped;
  logic          wrap_need;
  logic          no_fit;
  logic          cnt_sat;
  logic [QW-1:0] cnt_load;

  // handshake
  assign accept   = in_valid && (op == DP_LOAD);
  assign in_stall = (op != DP_LOAD);
  assign out_free = !out_valid_r || !out_stall;

  // arithmetic on the working copy
  assign x_sum      = DW'(x_r) + DW'(w_r);
  assign y_step_sum = DW'(y_r) + DW'(s_r);
  assign y_h_sum    = DW'(y_r) + DW'(h_r);
  assign wrap_need  = x_sum > DW'(atlas_w);
  assign no_fit     = y_h_sum > DW'(atlas_h);
  assign y_wrapped  = (y_step_sum > DW'(CURSOR_MAX)) ? CW'(CURSOR_MAX) : CW'(y_step_sum);

  // query count saturation
  assign cnt_sat  = 32'(in_rect_count) > MAX_QUERY_COUNT;
  assign cnt_load = cnt_sat ? QW'(MAX_QUERY_COUNT) : QW'(in_rect_count);

  assign status = '{accept:   accept,
                    qdone:    query_r && (cnt_r == '0),
                    no_fit:   no_fit,
                    is_query: query_r,
                    out_free: out_free};

  // next values per control word
  always_comb begin
    cursor_x_nxt    = cursor_x_r;
    cursor_y_nxt    = cursor_y_r;
    row_h_nxt       = row_h_r;
    full_nxt        = full_r;
    query_nxt       = query_r;
    w_nxt           = w_r;
    h_nxt           = h_r;
    cnt_nxt         = cnt_r;
    x_nxt           = x_r;
    y_nxt           = y_r;
    s_nxt           = s_r;
    cl_nxt          = cl_r;
    ct_nxt          = ct_r;
    cr_nxt          = cr_r;
    cb_nxt          = cb_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_success_nxt = out_success_r;
    out_left_nxt    = out_left_r;
    out_top_nxt     = out_top_r;
    out_right_nxt   = out_right_r;
    out_bottom_nxt  = out_bottom_r;
    out_full_nxt    = out_full_r;
    case (op)
      DP_LOAD: begin
        if (accept) begin
          query_nxt = (in_operation == OP_QUERY);
          w_nxt     = in_rect_width;
          h_nxt     = in_rect_height;
          cnt_nxt   = cnt_load;
          x_nxt     = cursor_x_r;
          y_nxt     = cursor_y_r;
          s_nxt     = row_h_r;
        end
      end
      DP_ADVANCE: begin
        // wrap to a new row; a pack restarts the row height
        if (wrap_need) begin
          x_nxt = '0;
          y_nxt = y_wrapped;
          if (!query_r) begin
            s_nxt = '0;
          end
        end
      end
      DP_PLACE: begin
        cl_nxt = x_r;
        ct_nxt = AXIS_W'(y_r);
        cr_nxt = AXIS_W'(x_sum);
        cb_nxt = AXIS_W'(y_h_sum);
        x_nxt  = AXIS_W'(x_sum);
        s_nxt  = (h_r > s_r) ? h_r : s_r;
        if (query_r) begin
          cnt_nxt = cnt_r - QW'(1);
        end
      end
      DP_EMIT_OK: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_success_nxt = 1'b1;
          out_full_nxt    = full_r;
          if (query_r) begin
            out_left_nxt   = '0;
            out_top_nxt    = '0;
            out_right_nxt  = '0;
            out_bottom_nxt = '0;
          end else begin
            out_left_nxt   = cl_r;
            out_top_nxt    = ct_r;
            out_right_nxt  = cr_r;
            out_bottom_nxt = cb_r;
            cursor_x_nxt   = x_r;
            cursor_y_nxt   = y_r;
            row_h_nxt      = s_r;
          end
        end
      end
      DP_EMIT_FAIL: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_success_nxt = 1'b0;
          out_left_nxt    = '0;
          out_top_nxt     = '0;
          out_right_nxt   = '0;
          out_bottom_nxt  = '0;
          // a failed pack keeps the wrapped cursor and sets the sticky flag
          if (query_r) begin
            out_full_nxt = full_r;
          end else begin
            out_full_nxt = 1'b1;
            full_nxt     = 1'b1;
            cursor_x_nxt = x_r;
            cursor_y_nxt = y_r;
            row_h_nxt    = s_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      row_h_r     <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      row_h_r     <= row_h_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    query_r       <= query_nxt;
    w_r           <= w_nxt;
    h_r           <= h_nxt;
    cnt_r         <= cnt_nxt;
    x_r           <= x_nxt;
    y_r           <= y_nxt;
    s_r           <= s_nxt;
    cl_r          <= cl_nxt;
    ct_r          <= ct_nxt;
    cr_r          <= cr_nxt;
    cb_r          <= cb_nxt;
    out_success_r <= out_success_nxt;
    out_left_r    <= out_left_nxt;
    out_top_r     <= out_top_nxt;
    out_right_r   <= out_right_nxt;
    out_bottom_r  <= out_bottom_nxt;
    out_full_r    <= out_full_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_success    = out_success_r;
  assign out_left       = out_left_r;
  assign out_top        = out_top_r;
  assign out_right      = out_right_r;
  assign out_bottom     = out_bottom_r;
  assign out_atlas_full = out_full_r;

endmodule

// ----- tb/tb_shelf_rect_packer.sv -----
`timescale 1ns / 1ps
module tb_shelf_rect_packer;
  import srp_pkg::*;

  localparam int SIDE_CAP      = 4096;
  localparam int COUNT_CAP     = 256;
  localparam int Y_CAP         = 2 * SIDE_CAP - 1;
  localparam int RANDOM_ITEMS  = 850;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 8;

  // one result transaction as the block reports it
  typedef struct packed {
    logic              success;
    logic [AXIS_W-1:0] left;
    logic [AXIS_W-1:0] top;
    logic [AXIS_W-1:0] right;
    logic [AXIS_W-1:0] bottom;
    logic              atlas_full;
  } placement_t;

  // shadow of the atlas cursor and the placements still owed by the block
  class placement_board;
    logic [AXIS_W-1:0] atlas_w;
    logic [AXIS_W-1:0] atlas_h;
    logic [AXIS_W-1:0] cur_x;
    logic [AXIS_W-1:0] cur_y;
    logic [AXIS_W-1:0] shelf_h;
    logic              full;
    placement_t        due_q[$];
    int                errors;

    function new();
      atlas_w = AXIS_W'(1024);
      atlas_h = AXIS_W'(1024);
      cur_x   = '0;
      cur_y   = '0;
      shelf_h = '0;
      full    = 1'b0;
      errors  = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [AXIS_W-1:0] val);
      if (idx == REG_ATLAS_WIDTH) atlas_w = val;
      else if (idx == REG_ATLAS_HEIGHT) atlas_h = val;
    endfunction

    // register values past the largest side behave as the largest side
    function int unsigned usable(logic [AXIS_W-1:0] side);
      return (side > SIDE_CAP) ? SIDE_CAP : int'(side);
    endfunction

    // walk n equal rectangles from the cursor, leaving the cursor alone;
    // the row height is never restarted on a wrap here
    function bit all_fit(int unsigned n, int unsigned w, int unsigned h);
      int unsigned x, y, step, aw, ah;
      x    = cur_x;
      y    = cur_y;
      step = shelf_h;
      aw   = usable(atlas_w);
      ah   = usable(atlas_h);
      if (n > COUNT_CAP) n = COUNT_CAP;
      for (int unsigned i = 0; i < n; i++) begin
        if (x + w > aw) begin
          x = 0;
          y = y + step;
          if (y > Y_CAP) y = Y_CAP;
        end
        if (y + h > ah) return 1'b0;
        x = x + w;
        if (h > step) step = h;
      end
      return 1'b1;
    endfunction

    // accepted input transaction: work out its result and queue it
    function void note_item(logic op, logic [RECT_W-1:0] w, logic [RECT_W-1:0] h,
                            logic [CNT_W-1:0] n);
      placement_t  res;
      int unsigned x, y, step, aw, ah;
      res  = '0;
      x    = cur_x;
      y    = cur_y;
      step = shelf_h;
      aw   = usable(atlas_w);
      ah   = usable(atlas_h);
      if (op == OP_PACK) begin
        // wrap to a fresh shelf when the right edge is passed
        if (x + w > aw) begin
          x    = 0;
          y    = y + step;
          if (y > Y_CAP) y = Y_CAP;
          step = 0;
        end
        if (y + h > ah) begin
          full = 1'b1;
        end else begin
          res.success = 1'b1;
          res.left    = AXIS_W'(x);
          res.top     = AXIS_W'(y);
          res.right   = AXIS_W'(x + w);
          res.bottom  = AXIS_W'(y + h);
          x           = x + w;
          if (h > step) step = h;
        end
        cur_x   = AXIS_W'(x);
        cur_y   = AXIS_W'(y);
        shelf_h = AXIS_W'(step);
      end else begin
        res.success = all_fit(n, w, h);
      end
      res.atlas_full = full;
      due_q.push_back(res);
    endfunction

    function void field_check(string field, int unsigned want, int unsigned got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    // accepted result transaction against the oldest owed placement
    function void check_result(placement_t got);
      placement_t want;
      if (due_q.size() == 0) begin
        $error("result transaction with no expectation waiting");
        errors++;
        return;
      end
      want = due_q.pop_front();
      field_check("success", want.success, got.success);
      field_check("left", want.left, got.left);
      field_check("top", want.top, got.top);
      field_check("right", want.right, got.right);
      field_check("bottom", want.bottom, got.bottom);
      field_check("atlas_full", want.atlas_full, got.atlas_full);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_operation;
  logic [RECT_W-1:0]    in_rect_width;
  logic [RECT_W-1:0]    in_rect_height;
  logic [CNT_W-1:0]     in_rect_count;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_success;
  logic [AXIS_W-1:0]    out_left;
  logic [AXIS_W-1:0]    out_top;
  logic [AXIS_W-1:0]    out_right;
  logic [AXIS_W-1:0]    out_bottom;
  logic                 out_atlas_full;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [AXIS_W-1:0]    cfg_data;

  placement_board board = new();
  bit             in_quiet  = 1'b0;
  bit             out_quiet = 1'b0;
  int             cycles    = 0;

  shelf_rect_packer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_rect_count  (in_rect_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_success    (out_success),
    .out_left       (out_left),
    .out_top        (out_top),
    .out_right      (out_right),
    .out_bottom     (out_bottom),
    .out_atlas_full (out_atlas_full),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // atlas side register value, roomy ones keep the cursor going longer
  function automatic logic [AXIS_W-1:0] pick_side(bit roomy);
    int r;
    r = $urandom_range(0, 99);
    if (roomy) begin
      if (r < 40) return AXIS_W'(4096);
      if (r < 60) return AXIS_W'(8191);
      if (r < 80) return AXIS_W'($urandom_range(3000, 4096));
      return AXIS_W'($urandom_range(0, 8191));
    end
    if (r < 15) return '0;
    if (r < 30) return AXIS_W'(1);
    if (r < 55) return AXIS_W'($urandom_range(2, 64));
    if (r < 80) return AXIS_W'($urandom_range(65, 4096));
    return AXIS_W'($urandom_range(0, 8191));
  endfunction

  // result side back-pressure
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      hold = pick_gap(out_quiet);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(placement_t'{out_success, out_left, out_top, out_right,
                                      out_bottom, out_atlas_full});
  end

  // one input transaction; valid stays up afterwards so that the next one can follow
  task automatic send_item(logic op, logic [RECT_W-1:0] w, logic [RECT_W-1:0] h,
                           logic [CNT_W-1:0] n);
    int gap;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_rect_width  <= w;
    in_rect_height <= h;
    in_rect_count  <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(op, w, h, n);
  endtask

  // drop valid and hold off until every owed placement has come back
  task automatic rest_sender();
    if (board.due_q.size() != 0) begin
      in_valid <= 1'b0;
      while (board.due_q.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [AXIS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_register(idx, val);
  endtask

  // only called with the block idle; ends on a fresh clock edge
  task automatic set_atlas(bit wr_w, logic [AXIS_W-1:0] wv, bit wr_h,
                           logic [AXIS_W-1:0] hv);
    if (wr_w) write_reg(REG_ATLAS_WIDTH, wv);
    if (wr_h) write_reg(REG_ATLAS_HEIGHT, hv);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stimulus
  initial begin
    int                sent;
    int                phase_left;
    int                r;
    int unsigned       wcap;
    int unsigned       hsmall;
    logic              op;
    logic [RECT_W-1:0] w;
    logic [RECT_W-1:0] h;
    logic [CNT_W-1:0]  n;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_PACK;
    in_rect_width  = '0;
    in_rect_height = '0;
    in_rect_count  = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_ATLAS_WIDTH;
    cfg_data       = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset atlas: empty query, zero rectangle, exact width, wraps, oversize
    send_item(OP_QUERY, 12'd4095, 12'd4095, 9'd0);
    send_item(OP_PACK, 12'd0, 12'd0, 9'd0);
    send_item(OP_PACK, 12'd1024, 12'd16, 9'd0);
    send_item(OP_PACK, 12'd1, 12'd8, 9'd0);
    send_item(OP_PACK, 12'd4095, 12'd1, 9'd511);
    send_item(OP_QUERY, 12'd1, 12'd1, 9'd256);
    send_item(OP_QUERY, 12'd4, 12'd4, 9'd511);
    send_item(OP_QUERY, 12'd0, 12'd1000, 9'd1);
    // too tall: flag goes up, later packs are still tried
    send_item(OP_PACK, 12'd100, 12'd4095, 9'd0);
    send_item(OP_PACK, 12'd10, 12'd10, 9'd0);
    send_item(OP_QUERY, 12'd2048, 12'd2048, 9'd3);

    // zero sized atlas
    rest_sender();
    set_atlas(1'b1, '0, 1'b1, '0);
    send_item(OP_PACK, 12'd0, 12'd0, 9'd0);
    send_item(OP_PACK, 12'd1, 12'd1, 9'd0);
    send_item(OP_QUERY, 12'd0, 12'd0, 9'd2);

    // registers past the largest side
    rest_sender();
    set_atlas(1'b1, AXIS_W'(8191), 1'b1, AXIS_W'(8191));
    send_item(OP_PACK, 12'd4095, 12'd4095, 9'd0);
    send_item(OP_PACK, 12'd2, 12'd2, 9'd0);
    send_item(OP_QUERY, 12'd7, 12'd3, 9'd300);

    // one pixel wide atlas
    rest_sender();
    set_atlas(1'b1, AXIS_W'(1), 1'b1, AXIS_W'(4096));
    send_item(OP_PACK, 12'd1, 12'd2, 9'd0);
    send_item(OP_PACK, 12'd1, 12'd2, 9'd0);
    send_item(OP_QUERY, 12'd1, 12'd1, 9'd5);

    rest_sender();
    set_atlas(1'b1, AXIS_W'(4096), 1'b1, AXIS_W'(4096));

    // random phases, each with its own idling profile and a chance of new atlas sides
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      rest_sender();
      set_atlas($urandom_range(0, 3) == 0, pick_side($urandom_range(0, 9) != 0),
                $urandom_range(0, 3) == 0, pick_side($urandom_range(0, 4) != 0));
      in_quiet   = ($urandom_range(0, 3) == 0);
      out_quiet  = ($urandom_range(0, 3) == 0);
      phase_left = $urandom_range(20, 80);
      while (phase_left > 0 && sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 59) == 0) rest_sender();
        wcap   = board.usable(board.atlas_w);
        hsmall = (wcap < 256) ? 1 : 7;
        op     = ($urandom_range(0, 9) < 3) ? OP_QUERY : OP_PACK;
        r      = $urandom_range(0, 99);
        if (r < 55) w = RECT_W'($urandom_range(0, 63));
        else if (r < 85) w = RECT_W'($urandom_range(0, (wcap > 4095) ? 4095 : wcap));
        else w = RECT_W'($urandom_range(0, 4095));
        r = $urandom_range(0, 99);
        if (r < 75) h = RECT_W'($urandom_range(0, hsmall));
        else if (r < 93) h = RECT_W'($urandom_range(0, 255));
        else h = RECT_W'($urandom_range(0, 4095));
        r = $urandom_range(0, 99);
        if (r < 50) n = CNT_W'($urandom_range(0, 8));
        else if (r < 85) n = CNT_W'($urandom_range(0, 40));
        else n = CNT_W'($urandom_range(0, 511));
        send_item(op, w, h, n);
        phase_left--;
        sent++;
      end
    end

    // drain and let the block settle
    rest_sender();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/srp_pkg.sv
src/srp_seq.sv
src/srp_dp.sv
src/shelf_rect_packer.sv
tb/tb_shelf_rect_packer.sv
